// ===== hdl/assert_macros.svh =====
// assertion helpers, sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hdl/cmsb_pkg.sv =====
package cmsb_pkg;

  // default geometry and number format
  localparam int LANES_DEF       = 8;
  localparam int TILE_PIXELS_DEF = 256;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int ACC_WIDTH_DEF   = 40;

  // fixed field widths of the stream ports
  localparam int IO_LANES   = 8;
  localparam int DATA_W     = 16;
  localparam int PIX_W      = 8;
  localparam int SLOPE_W    = 9;
  localparam int SLOPE_FRAC = 8;

  localparam logic [SLOPE_W-1:0] SLOPE_RESET = 9'd26;

  // register indexes of the configuration port
  typedef enum logic [0:0] {
    CFG_LEAKY_EN    = 1'b0,
    CFG_LEAKY_SLOPE = 1'b1
  } cfg_idx_e;

  // item kinds carried in tuser
  typedef enum logic [0:0] {
    FUNC_ACC    = 1'b0,
    FUNC_FINISH = 1'b1
  } func_e;

  // per item operation flags
  typedef struct packed {
    logic fin;
    logic clear;
  } op_t;

endpackage

// ===== hdl/cmsb_ram.sv =====
module cmsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port, read returns old data on collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hdl/cmsb_lane.sv =====
module cmsb_lane #(
  parameter int ACC_WIDTH = 40,
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  cmsb_pkg::op_t                 load_op_i,
  input  logic signed [15:0]            act_i,
  input  logic signed [15:0]            coef_i,
  input  cmsb_pkg::op_t                 op_i,
  input  logic [ACC_WIDTH-1:0]          acc_i,
  output logic [ACC_WIDTH-1:0]          acc_o,
  output logic [cmsb_pkg::DATA_W-1:0]   res_o
);

  import cmsb_pkg::*;

  logic signed [2*DATA_W-1:0]  prod;
  logic signed [ACC_WIDTH-1:0] bias_ext;
  logic [ACC_WIDTH-1:0]        term_d, term_q;

  // product on accumulate, bias aligned to the product fraction on finish
  always_comb begin
    prod     = act_i * coef_i;
    bias_ext = ACC_WIDTH'(coef_i);
    if (load_op_i.fin) begin
      term_d = ACC_WIDTH'(bias_ext <<< FRAC_BITS);
    end else begin
      term_d = ACC_WIDTH'(prod);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      term_q <= term_d;
    end
  end

  // overwrite or add, wrapping at the accumulator width
  always_comb begin
    if (op_i.clear) begin
      acc_o = term_q;
    end else begin
      acc_o = acc_i + term_q;
    end
    res_o = acc_o[FRAC_BITS +: DATA_W];
  end

endmodule

// ===== hdl/cmsb_leaky.sv =====
module cmsb_leaky (
  input  logic [cmsb_pkg::DATA_W-1:0]  res_i,
  input  logic                         en_i,
  input  logic [cmsb_pkg::SLOPE_W-1:0] slope_i,
  output logic [cmsb_pkg::DATA_W-1:0]  res_o
);

  import cmsb_pkg::*;

  logic signed [DATA_W+SLOPE_W:0] prod;

  // negative results scaled by the unsigned Q1.8 slope, floor then wrap
  always_comb begin
    prod = $signed(res_i) * $signed({1'b0, slope_i});
    if (en_i && res_i[DATA_W-1]) begin
      res_o = prod[SLOPE_FRAC +: DATA_W];
    end else begin
      res_o = res_i;
    end
  end

endmodule

// ===== hdl/conv_mac_strip_bias_lrelu.sv =====
// Output-stationary MAC strip: LANES accumulators per tile pixel live in one
// synchronous RAM row (LANES x ACC_WIDTH bits, TILE_PIXELS rows) that is read when
// an item is accepted and written back in the next cycle; a forwarding register
// covers back-to-back items on the same pixel. Accumulate items are taken one per
// cycle. A finish item adds the biases, applies leaky ReLU in a second stage and
// lands in the output register; input is held off while it is in those two
// stages, including while stage 2 waits for the output register. Pixel indexes
// wrap modulo TILE_PIXELS while out_pixel echoes the raw field. Accumulators have
// no reset: the first access to a pixel after reset must carry the clear flag.
// Lanes above LANES read as zero. The user must write configuration only while
// the block is idle; the block itself does not enforce it.
`include "assert_macros.svh"

module conv_mac_strip_bias_lrelu #(
  parameter int LANES       = cmsb_pkg::LANES_DEF,
  parameter int TILE_PIXELS = cmsb_pkg::TILE_PIXELS_DEF,
  parameter int FRAC_BITS   = cmsb_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH   = cmsb_pkg::ACC_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [cmsb_pkg::SLOPE_W-1:0]  cfg_wdata_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pixel, act_value, lane0_coef .. lane7_coef
  input  logic [151:0]                  s_axis_tdata,
  // func, clear
  input  logic [1:0]                    s_axis_tuser,
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_pixel, lane0_out .. lane7_out
  output logic [135:0]                  m_axis_tdata
);

  import cmsb_pkg::*;

  localparam int AW    = (TILE_PIXELS > 1) ? $clog2(TILE_PIXELS) : 1;
  localparam int ROW_W = LANES * ACC_WIDTH;

  // pixel index modulo the tile, by restoring subtraction
  function automatic logic [AW-1:0] wrap_pixel(input logic [PIX_W-1:0] p);
    logic [20:0] v;
    v = 21'(p);
    for (int s = 7; s >= 0; s--) begin
      if (v >= (21'(TILE_PIXELS) << s)) begin
        v = v - (21'(TILE_PIXELS) << s);
      end
    end
    return v[AW-1:0];
  endfunction

  // configuration registers
  logic               leaky_en_q;
  logic [SLOPE_W-1:0] slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaky_en_q <= 1'b0;
      slope_q    <= SLOPE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_LEAKY_EN:    leaky_en_q <= cfg_wdata_i[0];
        CFG_LEAKY_SLOPE: slope_q    <= cfg_wdata_i;
      endcase
    end
  end

  // input side
  logic             in_fire;
  op_t              in_op;
  logic [PIX_W-1:0] in_pix;
  logic [AW-1:0]    in_addr;
  logic             s1_valid_q, s2_valid_q;
  op_t              s1_op_q;

  assign s_axis_tready = !(s1_valid_q && s1_op_q.fin) && !s2_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_op.fin     = (func_e'(s_axis_tuser[0]) == FUNC_FINISH);
  assign in_op.clear   = s_axis_tuser[1] && !in_op.fin;
  assign in_pix        = s_axis_tdata[PIX_W-1:0];
  assign in_addr       = wrap_pixel(in_pix);

  // stage 1: read data back, update or add bias
  logic [AW-1:0]    s1_addr_q;
  logic [PIX_W-1:0] s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= in_op;
      s1_addr_q <= in_addr;
      s1_pix_q  <= in_pix;
    end
  end

  // accumulator memory and write-back forwarding
  logic             ram_we;
  logic [ROW_W-1:0] ram_rdata, ram_wdata, acc_row;
  logic             fwd_valid_q;
  logic [AW-1:0]    fwd_addr_q;
  logic [ROW_W-1:0] fwd_data_q;

  assign ram_we = s1_valid_q && !s1_op_q.fin;

  cmsb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TILE_PIXELS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= ram_wdata;
    end
  end

  // the row written at the read edge is newer than the ram output
  assign acc_row = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;

  // lane datapaths
  logic [DATA_W-1:0] lane_res [LANES];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    cmsb_lane #(
      .ACC_WIDTH (ACC_WIDTH),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .load_i    (in_fire),
      .load_op_i (in_op),
      .act_i     ($signed(s_axis_tdata[PIX_W +: DATA_W])),
      .coef_i    ($signed(s_axis_tdata[PIX_W + DATA_W*(k+1) +: DATA_W])),
      .op_i      (s1_op_q),
      .acc_i     (acc_row[k*ACC_WIDTH +: ACC_WIDTH]),
      .acc_o     (ram_wdata[k*ACC_WIDTH +: ACC_WIDTH]),
      .res_o     (lane_res[k])
    );
  end

  // stage 2: leaky relu, waits here while the output register is full
  logic [DATA_W-1:0] s2_res_q [LANES];
  logic [DATA_W-1:0] s2_act   [LANES];
  logic [PIX_W-1:0]  s2_pix_q;
  logic              s2_move;
  logic              out_valid_q;

  assign s2_move = s2_valid_q && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_valid_q && s1_op_q.fin) begin
      s2_valid_q <= 1'b1;
    end else if (s2_move) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_op_q.fin) begin
      s2_res_q <= lane_res;
      s2_pix_q <= s1_pix_q;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_leaky
    cmsb_leaky u_leaky (
      .res_i   (s2_res_q[k]),
      .en_i    (leaky_en_q),
      .slope_i (slope_q),
      .res_o   (s2_act[k])
    );
  end

  // output register
  logic [DATA_W-1:0] out_res_q [LANES];
  logic [PIX_W-1:0]  out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_res_q <= s2_act;
      out_pix_q <= s2_pix_q;
    end
  end

  assign m_axis_tvalid            = out_valid_q;
  assign m_axis_tdata[PIX_W-1:0] = out_pix_q;

  for (genvar k = 0; k < IO_LANES; k++) begin : g_out
    if (k < LANES) begin : g_used
      assign m_axis_tdata[PIX_W + DATA_W*k +: DATA_W] = out_res_q[k];
    end else begin : g_zero
      assign m_axis_tdata[PIX_W + DATA_W*k +: DATA_W] = '0;
    end
  end

  // checks
  `ASSERT_NEVER(a_fin_s2_busy, s1_valid_q && s1_op_q.fin && s2_valid_q, "finish met busy stage 2")
  `ASSERT_CLK(a_fin_reaches_s2, (in_fire && in_op.fin) |-> ##2 s2_valid_q, "finish lost")
  `ASSERT_CLK(a_out_from_s2, $rose(out_valid_q) |-> $past(s2_valid_q), "result without source")

endmodule

// ===== verif/tb_conv_mac_strip_bias_lrelu.sv =====
module tb_conv_mac_strip_bias_lrelu;
  timeunit 1ns;
  timeprecision 1ps;

  import cmsb_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned ITEMS_PER_PHASE = 330;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned HOLD_AFTER      = 700;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned MAX_PRINTS      = 40;
  localparam int          ACC_W           = ACC_WIDTH_DEF;
  localparam int          TILE            = TILE_PIXELS_DEF;

  // one input item as the block sees it
  typedef struct packed {
    func_e                             func;
    logic                              clear;
    logic [PIX_W-1:0]                  pixel;
    logic [DATA_W-1:0]                 act;
    logic [IO_LANES-1:0][DATA_W-1:0]   coef;
  } mac_item_t;

  // one result item, laid out as on m_axis_tdata (pixel in the low bits)
  typedef struct packed {
    logic [IO_LANES-1:0][DATA_W-1:0]   lane;
    logic [PIX_W-1:0]                  pixel;
  } strip_result_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we        = 1'b0;
  cfg_idx_e             cfg_addr      = CFG_LEAKY_EN;
  logic [SLOPE_W-1:0]   cfg_wdata     = '0;
  logic                 s_valid       = 1'b0;
  logic                 s_ready;
  // pixel, act_value, lane0_coef .. lane7_coef
  logic [151:0]         s_data        = '0;
  // func, clear
  logic [1:0]           s_user        = '0;
  logic                 m_valid;
  logic                 m_ready       = 1'b0;
  // out_pixel, lane0_out .. lane7_out
  logic [135:0]         m_data;

  // shadow of the block's state and registers
  logic [ACC_W-1:0]     lane_acc [IO_LANES][TILE];
  bit                   pixel_cleared [TILE];
  logic                 leaky_en_cfg    = 1'b0;
  logic [SLOPE_W-1:0]   leaky_slope_cfg = SLOPE_RESET;

  mac_item_t            pending_items [$];
  strip_result_t        expected_results [$];
  mac_item_t            cur_item;

  int unsigned mismatches      = 0;
  int unsigned items_accepted  = 0;
  int unsigned accum_items     = 0;
  int unsigned finish_items    = 0;
  int unsigned results_checked = 0;
  int unsigned leaky_hits      = 0;
  int unsigned settings_run    = 1;
  int unsigned cycle_count     = 0;
  int          burst_left      = 0;
  int          gap_left        = 0;
  int          hold_left       = 0;
  bit          hold_done       = 1'b0;
  int          ready_mode      = 0;
  int          mode_left       = 0;
  logic [PIX_W-1:0] window_base = '0;

  conv_mac_strip_bias_lrelu i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // bias add, truncation to q7.8 and optional leaky slope for one lane
  function automatic logic [DATA_W-1:0] biased_lane_out(logic [ACC_W-1:0] acc,
                                                        logic [DATA_W-1:0] bias);
    logic [ACC_W-1:0]   sum;
    logic [DATA_W-1:0]  r;
    logic signed [25:0] scaled;
    sum = acc + {{(ACC_W-DATA_W-FRAC_BITS_DEF){bias[DATA_W-1]}}, bias,
                 {FRAC_BITS_DEF{1'b0}}};
    r = sum[FRAC_BITS_DEF +: DATA_W];
    if (leaky_en_cfg && r[DATA_W-1]) begin
      leaky_hits++;
      scaled = $signed(r) * $signed({1'b0, leaky_slope_cfg});
      r = scaled[SLOPE_FRAC +: DATA_W];
    end
    return r;
  endfunction

  // update the accumulator shadow and queue the result a finish item causes
  task automatic apply_item(mac_item_t it);
    strip_result_t      res;
    logic signed [31:0] prod;
    int                 row;
    row = int'(it.pixel) % TILE;
    items_accepted++;
    if (it.func == FUNC_ACC) begin
      accum_items++;
      for (int k = 0; k < IO_LANES; k++) begin
        prod = $signed(it.act) * $signed(it.coef[k]);
        if (it.clear) begin
          lane_acc[k][row] = {{(ACC_W-32){prod[31]}}, prod};
        end else begin
          lane_acc[k][row] = lane_acc[k][row] + {{(ACC_W-32){prod[31]}}, prod};
        end
      end
    end else begin
      finish_items++;
      res.pixel = it.pixel;
      for (int k = 0; k < IO_LANES; k++) begin
        res.lane[k] = biased_lane_out(lane_acc[k][row], it.coef[k]);
      end
      expected_results.push_back(res);
    end
  endtask

  task automatic check_result(strip_result_t got);
    strip_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result for pixel %0d with none expected", got.pixel));
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (got.pixel !== want.pixel) begin
        report_mismatch($sformatf("out_pixel got %0d want %0d", got.pixel, want.pixel));
      end
      for (int k = 0; k < IO_LANES; k++) begin
        if (got.lane[k] !== want.lane[k]) begin
          report_mismatch($sformatf("pixel %0d lane %0d got %h want %h",
                                    want.pixel, k, got.lane[k], want.lane[k]));
        end
      end
    end
  endtask

  // keep accumulators defined: the first touch of a pixel must clear it
  task automatic queue_item(mac_item_t it);
    if (!pixel_cleared[it.pixel] && !(it.func == FUNC_ACC && it.clear)) begin
      it.func  = FUNC_ACC;
      it.clear = 1'b1;
    end
    if (it.func == FUNC_ACC && it.clear) begin
      pixel_cleared[it.pixel] = 1'b1;
    end
    pending_items.push_back(it);
  endtask

  function automatic mac_item_t mk_item(func_e f, logic clr, logic [PIX_W-1:0] pix,
                                        logic [DATA_W-1:0] act, logic [127:0] coefs);
    mac_item_t it;
    it.func  = f;
    it.clear = clr;
    it.pixel = pix;
    it.act   = act;
    it.coef  = coefs;
    return it;
  endfunction

  // q7.8 value: extremes, small magnitudes or anything
  function automatic logic [DATA_W-1:0] rand_q78();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      case ($urandom_range(0, 4))
        0:       return 16'h8000;
        1:       return 16'h7fff;
        2:       return 16'h0000;
        3:       return 16'hffff;
        default: return 16'h0001;
      endcase
    end
    if (sel < 50) begin
      return 16'(int'($urandom_range(0, 1023)) - 512);
    end
    return 16'($urandom);
  endfunction

  // mostly accumulate runs on a randomly moved window of pixels, with finishes mixed in
  task automatic queue_random(int unsigned count);
    mac_item_t   it;
    int unsigned sel;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        window_base = 8'($urandom);
      end
      if ($urandom_range(0, 99) < 65) begin
        it.pixel = window_base + 8'($urandom_range(0, 7));
      end else begin
        it.pixel = 8'($urandom_range(0, 255));
      end
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        it.func  = FUNC_ACC;
        it.clear = 1'b1;
      end else if (sel < 65) begin
        it.func  = FUNC_ACC;
        it.clear = 1'b0;
      end else begin
        it.func  = FUNC_FINISH;
        it.clear = 1'($urandom_range(0, 1));
      end
      it.act = rand_q78();
      for (int k = 0; k < IO_LANES; k++) begin
        it.coef[k] = rand_q78();
      end
      queue_item(it);
    end
  endtask

  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return 0;
    if (sel < 85) return $urandom_range(1, 4);
    return $urandom_range(8, 20);
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || s_valid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [SLOPE_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_LEAKY_EN:    leaky_en_cfg    = value[0];
      CFG_LEAKY_SLOPE: leaky_slope_cfg = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // input driver: bursts of items separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_ready) begin
      if (s_valid) begin
        apply_item(cur_item);
      end
      if (gap_left > 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        s_data  <= {cur_item.coef, cur_item.act, cur_item.pixel};
        s_user  <= {cur_item.clear, cur_item.func};
        s_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = pick_gap();
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // result receiver: changing stall modes and one long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_ready  <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0:       m_ready <= 1'b1;
        1:       m_ready <= 1'($urandom_range(0, 1));
        default: m_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      check_result(m_data);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("** conv_mac_strip_bias_lrelu: FAILED **");
      $finish;
    end
  end

  // stimulus: directed items, then random phases over several leaky settings
  initial begin
    logic               en_plan    [6];
    logic [SLOPE_W-1:0] slope_plan [6];
    en_plan    = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    slope_plan = '{9'd26, 9'd0, 9'd511, 9'd256, 9'd511, 9'($urandom_range(1, 255))};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extreme products, accumulate over a cleared entry, finish
    queue_item(mk_item(FUNC_ACC, 1'b1, 8'h00, 16'h7fff,
      {16'h4000, 16'hff00, 16'h0100, 16'h0001, 16'hffff, 16'h0000, 16'h7fff, 16'h8000}));
    queue_item(mk_item(FUNC_ACC, 1'b0, 8'h00, 16'h8000,
      {16'hfe00, 16'h0200, 16'h0000, 16'hffff, 16'h0001, 16'h7fff, 16'h8000, 16'h8000}));
    queue_item(mk_item(FUNC_FINISH, 1'b0, 8'h00, 16'h1234,
      {16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h0000, 16'h0100, 16'hff00, 16'h8000}));
    // top pixel, clear flag on finish is ignored, finish leaves accumulators alone
    queue_item(mk_item(FUNC_ACC, 1'b1, 8'hff, 16'hffff, {8{16'h8000}}));
    queue_item(mk_item(FUNC_ACC, 1'b0, 8'hff, 16'h0000, {8{16'h5a5a}}));
    queue_item(mk_item(FUNC_FINISH, 1'b1, 8'hff, 16'hffff, {8{16'h0000}}));
    queue_item(mk_item(FUNC_FINISH, 1'b0, 8'hff, 16'h0000, {8{16'h7fff}}));
    // negative results under the reset slope settings
    queue_item(mk_item(FUNC_ACC, 1'b1, 8'h80, 16'h0100,
      {16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'hff00, 16'hfe00, 16'hfd00, 16'hfc00}));
    queue_item(mk_item(FUNC_FINISH, 1'b0, 8'h80, 16'h0000, {8{16'hff00}}));
    // back-to-back items on one pixel
    queue_item(mk_item(FUNC_ACC, 1'b1, 8'h55, 16'h0080, {8{16'h0080}}));
    queue_item(mk_item(FUNC_ACC, 1'b0, 8'h55, 16'h0080, {8{16'h0080}}));
    queue_item(mk_item(FUNC_ACC, 1'b0, 8'h55, 16'hff80, {8{16'h0180}}));
    queue_item(mk_item(FUNC_FINISH, 1'b0, 8'h55, 16'h0000, {8{16'h0000}}));
    queue_item(mk_item(FUNC_ACC, 1'b1, 8'haa, 16'h8000, {8{16'h7fff}}));
    queue_item(mk_item(FUNC_FINISH, 1'b0, 8'haa, 16'h0000, {8{16'h8000}}));
    queue_item(mk_item(FUNC_ACC, 1'b1, 8'h01, 16'h7fff, {8{16'h7fff}}));
    queue_item(mk_item(FUNC_ACC, 1'b0, 8'h01, 16'h7fff, {8{16'h7fff}}));
    queue_item(mk_item(FUNC_ACC, 1'b0, 8'h01, 16'h7fff, {8{16'h7fff}}));
    queue_item(mk_item(FUNC_ACC, 1'b0, 8'h01, 16'h8000, {8{16'h8000}}));
    queue_item(mk_item(FUNC_FINISH, 1'b0, 8'h01, 16'h0000, {8{16'h0000}}));
    queue_item(mk_item(FUNC_FINISH, 1'b0, 8'h00, 16'h0000, {8{16'h0000}}));
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_LEAKY_EN, {{(SLOPE_W-1){1'b0}}, en_plan[p]});
      write_reg(CFG_LEAKY_SLOPE, slope_plan[p]);
      settings_run++;
      @(negedge clk_i);
      queue_random(ITEMS_PER_PHASE);
      wait_idle();
    end

    $display("covered %0d items (%0d accumulate, %0d finish) across %0d leaky settings",
             items_accepted, accum_items, finish_items, settings_run);
    $display("checked %0d results, %0d lanes went through the leaky slope, %0d mismatches",
             results_checked, leaky_hits, mismatches);
    if (mismatches == 0) begin
      $display("** conv_mac_strip_bias_lrelu: PASSED **");
    end else begin
      $display("** conv_mac_strip_bias_lrelu: FAILED **");
    end
    $finish;
  end

endmodule
